/* rtl/bdta_pkg.sv */
// Package for the binary to decimal ASCII core.
// Holds the ASCII codes, output slot sizes and elaboration-time helpers.
// Used by every module under rtl.
package bdta_pkg;

    localparam int CHAR_SLOTS = 6;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 3;
    localparam int LEN_MAX    = 7;
    localparam int ERR_LEN    = 3;
    localparam int IN_W       = 32;
    localparam int OUT_DATA_W = 56;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_E    = 8'h45;
    localparam logic [CHAR_W-1:0] ASCII_R    = 8'h52;

    function automatic logic [63:0] limit_of(input int digits);
        logic [63:0] lim;
        lim = 64'd1;
        for (int k = 0; k < digits; k++) begin
            lim = lim * 64'd10;
        end
        return lim - 64'd1;
    endfunction

    function automatic int bin_width(input int digits);
        logic [63:0] lim;
        int          w;
        lim = limit_of(digits);
        w   = 0;
        for (int k = 0; k < 64; k++) begin
            if ((lim >> k) != 64'd0) begin
                w = k + 1;
            end
        end
        return (w > IN_W) ? IN_W : w;
    endfunction

endpackage

/* rtl/bdta_cell.sv */
// One shift-and-adjust cell of the binary to BCD chain.
// Moves one binary bit into the BCD digits per transfer; depends on bdta_pkg.
module bdta_cell
    import bdta_pkg::*;
#(
    parameter int DIGITS = 6,
    parameter int BIN_W  = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_ovf,
    input  logic [4*DIGITS-1:0]   i_bcd,
    input  logic [BIN_W-1:0]      i_bin,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_ovf,
    output logic [4*DIGITS-1:0]   o_bcd,
    output logic [BIN_W-1:0]      o_bin
);

    logic                r_valid;
    logic                r_ovf;
    logic [4*DIGITS-1:0] r_bcd;
    logic [BIN_W-1:0]    r_bin;
    logic [4*DIGITS-1:0] n_adj;
    logic                adv;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;

    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (i_bcd[4*d +: 4] >= 4'd5) begin
                n_adj[4*d +: 4] = i_bcd[4*d +: 4] + 4'd3;
            end else begin
                n_adj[4*d +: 4] = i_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ovf <= i_ovf;
            r_bcd <= {n_adj[4*DIGITS-2:0], i_bin[BIN_W-1]};
            r_bin <= {i_bin[BIN_W-2:0], 1'b0};
        end
    end

    assign o_valid = r_valid;
    assign o_ovf   = r_ovf;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;

endmodule

/* rtl/bdta_format.sv */
// Output formatter and result register of the binary to decimal ASCII core.
// Blanks leading zeros, left-aligns the ASCII text, writes ERR on overflow; depends on bdta_pkg.
module bdta_format
    import bdta_pkg::*;
#(
    parameter int DIGITS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_ovf,
    input  logic [4*DIGITS-1:0]   i_bcd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam int ND_W = $clog2(DIGITS + 1);

    logic                          r_valid;
    logic [OUT_DATA_W-1:0]         r_data;
    logic [ND_W-1:0]               nd;
    logic [CHAR_SLOTS*CHAR_W-1:0]  n_chars;
    logic [LEN_W-1:0]              n_len;
    logic                          adv;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;

    always_comb begin
        nd = ND_W'(1);
        for (int j = 0; j < DIGITS; j++) begin
            if (i_bcd[4*j +: 4] != 4'd0) begin
                nd = ND_W'(j + 1);
            end
        end
    end

    always_comb begin
        n_chars = '0;
        n_len   = '0;
        if (i_ovf) begin
            n_chars[0*CHAR_W +: CHAR_W] = ASCII_E;
            n_chars[1*CHAR_W +: CHAR_W] = ASCII_R;
            n_chars[2*CHAR_W +: CHAR_W] = ASCII_R;
            n_len = LEN_W'(ERR_LEN);
        end else begin
            for (int k = 0; k < CHAR_SLOTS; k++) begin
                for (int j = 0; j < DIGITS; j++) begin
                    if (int'(nd) == j + k + 1) begin
                        n_chars[k*CHAR_W +: CHAR_W] = ASCII_ZERO | {4'd0, i_bcd[4*j +: 4]};
                    end
                end
            end
            n_len = (int'(nd) > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(nd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_data <= OUT_DATA_W'({i_ovf, n_len, n_chars});
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/binary_to_decimal_ascii_core.sv */
// Stages from input transfer to result: one input register,
// one double-dabble cell per binary bit, one format register.
// Throughput: one value per cycle; each stage advances whenever the next one is free.
// Reset: synchronous, active low; clears every valid flag, payload is not reset.
// Depends on bdta_pkg, bdta_cell and bdta_format.
module binary_to_decimal_ascii_core
    import bdta_pkg::*;
#(
    parameter int DIGITS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_W-1:0]       i_s_axis_tdata,   // value[31:0]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata    // char0..char5, text_length, overflow, pad
);

    localparam logic [63:0] LIMIT = limit_of(DIGITS);
    localparam int          BIN_W = bin_width(DIGITS);

    logic                r_in_valid;
    logic                r_in_ovf;
    logic [BIN_W-1:0]    r_in_bin;
    logic                in_adv;

    logic                cv   [BIN_W+1];
    logic                crdy [BIN_W+1];
    logic                covf [BIN_W+1];
    logic [4*DIGITS-1:0] cbcd [BIN_W+1];
    logic [BIN_W-1:0]    cbin [BIN_W+1];

    assign in_adv          = !r_in_valid || crdy[0];
    assign o_s_axis_tready = in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_in_ovf <= ({32'd0, i_s_axis_tdata} > LIMIT);
            r_in_bin <= i_s_axis_tdata[BIN_W-1:0];
        end
    end

    assign cv[0]   = r_in_valid;
    assign covf[0] = r_in_ovf;
    assign cbcd[0] = '0;
    assign cbin[0] = r_in_bin;

    for (genvar i = 0; i < BIN_W; i++) begin : g_cell
        bdta_cell #(
            .DIGITS (DIGITS),
            .BIN_W  (BIN_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cv[i]),
            .o_ready (crdy[i]),
            .i_ovf   (covf[i]),
            .i_bcd   (cbcd[i]),
            .i_bin   (cbin[i]),
            .o_valid (cv[i+1]),
            .i_ready (crdy[i+1]),
            .o_ovf   (covf[i+1]),
            .o_bcd   (cbcd[i+1]),
            .o_bin   (cbin[i+1])
        );
    end

    bdta_format #(
        .DIGITS (DIGITS)
    ) u_format (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cv[BIN_W]),
        .o_ready (crdy[BIN_W]),
        .i_ovf   (covf[BIN_W]),
        .i_bcd   (cbcd[BIN_W]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

/* rtl/bdta_checker.sv */
// Port-level checker for the binary to decimal ASCII core, bound to the top level.
// Depends on bdta_pkg.
module bdta_checker
    import bdta_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic             ovf;
    logic [LEN_W-1:0] len;

    assign ovf = o_m_axis_tdata[CHAR_SLOTS*CHAR_W+LEN_W];
    assign len = o_m_axis_tdata[CHAR_SLOTS*CHAR_W +: LEN_W];

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_err_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && ovf) |->
        (len == LEN_W'(ERR_LEN) && o_m_axis_tdata[CHAR_W-1:0] == ASCII_E &&
         o_m_axis_tdata[2*CHAR_W-1:CHAR_W] == ASCII_R &&
         o_m_axis_tdata[3*CHAR_W-1:2*CHAR_W] == ASCII_R &&
         o_m_axis_tdata[6*CHAR_W-1:3*CHAR_W] == '0))
        else $error("overflow result is not ERR");

    a_num_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !ovf) |->
        (len != '0 && o_m_axis_tdata[CHAR_W-1:4] == ASCII_ZERO[CHAR_W-1:4]))
        else $error("number result has no leading digit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind binary_to_decimal_ascii_core bdta_checker u_bdta_checker (.*);

/* tb/testbench.sv */
// Testbench for binary_to_decimal_ascii_core: drives 32-bit values, predicts the decimal text.
// Checks each result transfer in order with a small scoreboard, with random gaps on both sides.
// Depends on bdta_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import bdta_pkg::*;

    localparam int          DEC_DIGITS  = 6;
    localparam logic [31:0] DEC_LIMIT   = 32'd999_999;
    localparam int          RANDOM_ITEMS = 1880;
    localparam int          TAIL_CYCLES = 50;

    typedef struct packed {
        logic [IN_W-1:0]                   value;
        logic [CHAR_SLOTS-1:0][CHAR_W-1:0] chars;
        logic [LEN_W-1:0]                  length;
        logic                              overflow;
    } text_result_t;

    class decimal_text_scoreboard;
        text_result_t pending[$];
        int           errors;

        task report(input string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        function text_result_t decimal_text_of(input logic [IN_W-1:0] v);
            text_result_t r;
            logic [3:0]   dig [DEC_DIGITS];
            logic [31:0]  rest;
            int           nd;
            r       = '0;
            r.value = v;
            if (v > DEC_LIMIT) begin
                r.chars[0] = ASCII_E;
                r.chars[1] = ASCII_R;
                r.chars[2] = ASCII_R;
                r.length   = LEN_W'(ERR_LEN);
                r.overflow = 1'b1;
            end else begin
                rest = v;
                nd   = 1;
                for (int k = 0; k < DEC_DIGITS; k++) begin
                    dig[k] = 4'(rest % 32'd10);
                    rest   = rest / 32'd10;
                    if (dig[k] != 4'd0) begin
                        nd = k + 1;
                    end
                end
                for (int k = 0; k < nd; k++) begin
                    r.chars[k] = ASCII_ZERO + CHAR_W'(dig[nd-1-k]);
                end
                r.length = LEN_W'(nd);
            end
            return r;
        endfunction

        function void note_input(input logic [IN_W-1:0] v);
            pending.push_back(decimal_text_of(v));
        endfunction

        task check_result(input logic [OUT_DATA_W-1:0] data);
            text_result_t exp_r;
            logic [CHAR_W-1:0] got;
            if (pending.size() == 0) begin
                report($sformatf("result 0x%014h with no value pending", data));
            end else begin
                exp_r = pending.pop_front();
                for (int k = 0; k < CHAR_SLOTS; k++) begin
                    got = data[k*CHAR_W +: CHAR_W];
                    if (got !== exp_r.chars[k]) begin
                        report($sformatf("value %0d char%0d got 0x%02h want 0x%02h",
                                         exp_r.value, k, got, exp_r.chars[k]));
                    end
                end
                if (data[CHAR_SLOTS*CHAR_W +: LEN_W] !== exp_r.length) begin
                    report($sformatf("value %0d text_length got %0d want %0d", exp_r.value,
                                     data[CHAR_SLOTS*CHAR_W +: LEN_W], exp_r.length));
                end
                if (data[CHAR_SLOTS*CHAR_W+LEN_W] !== exp_r.overflow) begin
                    report($sformatf("value %0d overflow got %b want %b", exp_r.value,
                                     data[CHAR_SLOTS*CHAR_W+LEN_W], exp_r.overflow));
                end
            end
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [IN_W-1:0]       in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [OUT_DATA_W-1:0] out_data;
    logic                  no_idle   = 1'b0;

    decimal_text_scoreboard sb;

    binary_to_decimal_ascii_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),   // value[31:0]
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)   // char0..char5, text_length, overflow, pad
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_value(input logic [IN_W-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        do @(posedge clk); while (!in_ready);
        sb.note_input(v);
    endtask

    function automatic logic [31:0] pow10(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int k = 0; k < n; k++) begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    function automatic logic [IN_W-1:0] random_value();
        int          sel;
        int          n;
        logic [31:0] p;
        sel = $urandom_range(0, 9);
        if (sel <= 2) begin
            return $urandom();
        end else if (sel == 3) begin
            if ($urandom_range(0, 1) == 0) begin
                return DEC_LIMIT - $urandom_range(0, 20);
            end
            return DEC_LIMIT + 32'd1 + $urandom_range(0, 20);
        end else if (sel == 4) begin
            p = pow10($urandom_range(1, DEC_DIGITS));
            return p + $urandom_range(0, 2) - 32'd1;
        end
        n = $urandom_range(1, DEC_DIGITS);
        if (n == 1) begin
            return $urandom_range(0, 9);
        end
        return $urandom_range(pow10(n) - 1, pow10(n - 1));
    endfunction

    initial begin
        #10_000_000;
        $display("[binary_to_decimal_ascii_core] ERROR");
        $finish;
    end

    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    initial begin
        logic [IN_W-1:0] directed [$];
        sb = new;
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                     32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd123456, 32'd500000,
                     32'd999998, 32'd999999, 32'd1000000, 32'd1000001, 32'd100200,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'd7};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) begin
            send_value(directed[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle <= ((i / 150) % 3 == 2);
            send_value(random_value());
        end
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("[binary_to_decimal_ascii_core] OK");
        end else begin
            $display("[binary_to_decimal_ascii_core] ERROR");
        end
        $finish;
    end

endmodule

/* binary_to_decimal_ascii_core.f */
rtl/bdta_pkg.sv
rtl/bdta_cell.sv
rtl/bdta_format.sv
rtl/binary_to_decimal_ascii_core.sv
rtl/bdta_checker.sv
tb/testbench.sv
